// File: rtl/psbn_pkg.sv
// Package: types, constants and the code-to-ASCII decode for the entry parser.
`timescale 1ns / 1ps

package psbn_pkg;

    // Kinds of result carried on o_kind
    localparam logic [1:0] KIND_NAME_CHAR = 2'd0;
    localparam logic [1:0] KIND_FILE_CHAR = 2'd1;
    localparam logic [1:0] KIND_SAME_NAME = 2'd2;
    localparam logic [1:0] KIND_VOLUME    = 2'd3;

    // Result queue depth (power of two, pointers wrap)
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    localparam logic [7:0] MAX_LENGTH = 8'd127;

    typedef enum logic [4:0] {
        PH_NAME_LEN   = 5'b00001,
        PH_NAME_CHARS = 5'b00010,
        PH_FILE_LEN   = 5'b00100,
        PH_FILE_CHARS = 5'b01000,
        PH_VOLUME     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [31:0] volume_bits;
        logic        end_of_string;
        logic        end_of_entry;
        logic        length_error;
    } t_result;

    // 6-bit code to ASCII: 0, A-Z, a-z, 0-9, underscore
    function automatic logic [7:0] decode_code(input logic [5:0] code);
        logic [7:0] c;
        begin
            c = {2'b00, code};
            case (code) inside
                6'd0:          decode_code = 8'd0;
                [6'd1:6'd26]:  decode_code = c + 8'd64;
                [6'd27:6'd52]: decode_code = c + 8'd70;
                [6'd53:6'd62]: decode_code = c - 8'd5;
                default:       decode_code = 8'd95;
            endcase
        end
    endfunction

endpackage

// File: rtl/packed_six_bit_name_entry_parser_core.sv
// Top level: byte-stream parser for packed six-bit name list entries.
`timescale 1ns / 1ps

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  input    | in        | i_valid / o_ready  | i_data_byte
//  result   | out       | o_valid / i_ready  | o_kind, o_char_code, o_volume_bits,
//           |           |                    | o_end_of_string, o_end_of_entry,
//           |           |                    | o_length_error
//  config   | in        | i_cfg_wr_en        | i_cfg_wr_data (report_volume)
//
//  One byte per cycle while o_ready is high. A byte is decoded in the cycle it is taken and
//  its zero, one or two results enter a four-entry queue; into an empty queue, the first is
//  on the outputs the next cycle. o_ready is high while the queue holds two or fewer
//  results, so it depends only on registered state and a stall on the result side backs up
//  into the input once three or more results wait. Reset is synchronous, active low: parser
//  back to waiting for a name length, queue emptied, report_volume set to 1.

module packed_six_bit_name_entry_parser_core
    import psbn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_char_code,
    output logic [31:0] o_volume_bits,
    output logic        o_end_of_string,
    output logic        o_end_of_entry,
    output logic        o_length_error,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    // ---------------------------------------------------------------- parser state
    t_phase      r_phase,        n_phase;
    logic [6:0]  r_chars_left,   n_chars_left;
    logic [1:0]  r_group_pos,    n_group_pos;
    logic [7:0]  r_prev_byte,    n_prev_byte;
    logic [23:0] r_vol_shift,    n_vol_shift;
    logic [1:0]  r_vol_seen,     n_vol_seen;
    logic        r_entry_volume, n_entry_volume;
    logic        r_report_volume;

    // ---------------------------------------------------------------- result queue
    t_result               r_rq [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wr_ptr;
    logic [RQ_PTR_W-1:0]   r_rd_ptr;
    logic [RQ_CNT_W-1:0]   r_count;

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] n_push;
    t_result    res0, res1;

    // per-byte decode helpers
    logic [5:0] code0;
    logic [6:0] cl1, cl2;
    logic       last1, last2;
    logic       eoe_ok;
    logic       is_file;

    assign o_ready  = (r_count <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign in_xfer  = i_valid && o_ready;
    assign o_valid  = (r_count != '0);
    assign out_xfer = o_valid && i_ready;

    // ---------------------------------------------------------------- decode one byte
    always_comb begin
        n_phase        = r_phase;
        n_chars_left   = r_chars_left;
        n_group_pos    = r_group_pos;
        n_prev_byte    = r_prev_byte;
        n_vol_shift    = r_vol_shift;
        n_vol_seen     = r_vol_seen;
        n_entry_volume = r_entry_volume;
        n_push         = 2'd0;
        res0           = '0;
        res1           = '0;

        is_file = (r_phase == PH_FILE_CHARS);
        eoe_ok  = is_file && !r_entry_volume;

        // unpack: group position picks which bits form the next code
        case (r_group_pos)
            2'd0:    code0 = i_data_byte[7:2];
            2'd1:    code0 = {r_prev_byte[1:0], i_data_byte[7:4]};
            default: code0 = {r_prev_byte[3:0], i_data_byte[7:6]};
        endcase
        cl1   = r_chars_left - 7'd1;
        last1 = (cl1 == 7'd0);
        cl2   = cl1 - 7'd1;
        last2 = (cl2 == 7'd0);

        case (r_phase)
            PH_NAME_CHARS, PH_FILE_CHARS: begin
                if (r_chars_left == 7'd0) begin
                    // nothing left to read: move on without consuming codes
                    if (is_file) begin
                        n_phase     = PH_VOLUME;
                        n_vol_shift = '0;
                        n_vol_seen  = '0;
                    end else begin
                        n_phase = PH_FILE_LEN;
                    end
                end else begin
                    res0.kind          = is_file ? KIND_FILE_CHAR : KIND_NAME_CHAR;
                    res0.char_code     = decode_code(code0);
                    res0.end_of_string = last1;
                    res0.end_of_entry  = last1 && eoe_ok;
                    n_push             = 2'd1;
                    n_chars_left       = cl1;
                    n_prev_byte        = i_data_byte;
                    n_group_pos        = (r_group_pos == 2'd0) ? 2'd1 :
                                         (r_group_pos == 2'd1) ? 2'd2 : 2'd0;
                    // third byte of a group also carries a whole fourth code
                    if (!last1 && r_group_pos >= 2'd2) begin
                        res1.kind          = res0.kind;
                        res1.char_code     = decode_code(i_data_byte[5:0]);
                        res1.end_of_string = last2;
                        res1.end_of_entry  = last2 && eoe_ok;
                        n_push             = 2'd2;
                        n_chars_left       = cl2;
                    end
                    if (last1 || (r_group_pos >= 2'd2 && last2)) begin
                        n_group_pos = 2'd0;
                        if (is_file) begin
                            n_phase     = PH_VOLUME;
                            n_vol_shift = '0;
                            n_vol_seen  = '0;
                        end else begin
                            n_phase = PH_FILE_LEN;
                        end
                    end
                end
            end
            PH_FILE_LEN: begin
                if (i_data_byte == 8'd0) begin
                    res0.kind         = KIND_SAME_NAME;
                    res0.end_of_entry = !r_entry_volume;
                    n_push            = 2'd1;
                    n_phase           = PH_VOLUME;
                    n_vol_shift       = '0;
                    n_vol_seen        = '0;
                end else if (i_data_byte > MAX_LENGTH) begin
                    res0.kind          = KIND_FILE_CHAR;
                    res0.end_of_string = 1'b1;
                    res0.end_of_entry  = !r_entry_volume;
                    res0.length_error  = 1'b1;
                    n_push             = 2'd1;
                    n_phase            = PH_VOLUME;
                    n_vol_shift        = '0;
                    n_vol_seen         = '0;
                end else begin
                    n_chars_left = i_data_byte[6:0];
                    n_group_pos  = 2'd0;
                    n_phase      = PH_FILE_CHARS;
                end
            end
            PH_VOLUME: begin
                if (r_vol_seen != 2'd3) begin
                    n_vol_shift = {r_vol_shift[15:0], i_data_byte};
                    n_vol_seen  = r_vol_seen + 2'd1;
                end else begin
                    if (r_entry_volume) begin
                        res0.kind         = KIND_VOLUME;
                        res0.volume_bits  = {r_vol_shift, i_data_byte};
                        res0.end_of_entry = 1'b1;
                        n_push            = 2'd1;
                    end
                    n_vol_shift = '0;
                    n_vol_seen  = '0;
                    n_phase     = PH_NAME_LEN;
                end
            end
            default: begin
                // name length byte; volume reporting is latched per entry here
                n_entry_volume = r_report_volume;
                if (i_data_byte == 8'd0) begin
                    n_phase = PH_FILE_LEN;
                end else if (i_data_byte > MAX_LENGTH) begin
                    res0.kind          = KIND_NAME_CHAR;
                    res0.end_of_string = 1'b1;
                    res0.length_error  = 1'b1;
                    n_push             = 2'd1;
                    n_phase            = PH_FILE_LEN;
                end else begin
                    n_chars_left = i_data_byte[6:0];
                    n_group_pos  = 2'd0;
                    n_phase      = PH_NAME_CHARS;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_NAME_LEN;
            r_chars_left    <= '0;
            r_group_pos     <= '0;
            r_prev_byte     <= '0;
            r_vol_shift     <= '0;
            r_vol_seen      <= '0;
            r_entry_volume  <= 1'b1;
            r_report_volume <= 1'b1;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_report_volume <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_phase        <= n_phase;
                r_chars_left   <= n_chars_left;
                r_group_pos    <= n_group_pos;
                r_prev_byte    <= n_prev_byte;
                r_vol_shift    <= n_vol_shift;
                r_vol_seen     <= n_vol_seen;
                r_entry_volume <= n_entry_volume;
                r_wr_ptr       <= r_wr_ptr + RQ_PTR_W'(n_push);
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + RQ_PTR_W'(1);
            end
            r_count <= r_count + (in_xfer ? RQ_CNT_W'(n_push) : RQ_CNT_W'(0))
                               - (out_xfer ? RQ_CNT_W'(1) : RQ_CNT_W'(0));
        end
    end

    // ---------------------------------------------------------------- queue storage
    always_ff @(posedge i_clk) begin
        if (in_xfer && n_push != 2'd0) begin
            r_rq[r_wr_ptr] <= res0;
        end
        if (in_xfer && n_push == 2'd2) begin
            r_rq[r_wr_ptr + RQ_PTR_W'(1)] <= res1;
        end
    end

    assign o_kind          = r_rq[r_rd_ptr].kind;
    assign o_char_code     = r_rq[r_rd_ptr].char_code;
    assign o_volume_bits   = r_rq[r_rd_ptr].volume_bits;
    assign o_end_of_string = r_rq[r_rd_ptr].end_of_string;
    assign o_end_of_entry  = r_rq[r_rd_ptr].end_of_entry;
    assign o_length_error  = r_rq[r_rd_ptr].length_error;

    // ---------------------------------------------------------------- checks
    // queue never overfills
    a_rq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overfilled");

    // occupancy follows pushes and pops
    a_rq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count)
            + ($past(in_xfer) ? RQ_CNT_W'($past(n_push)) : RQ_CNT_W'(0))
            - ($past(out_xfer) ? RQ_CNT_W'(1) : RQ_CNT_W'(0)))
        else $error("result queue count out of step");

    // a volume word always closes its entry and is never a string end
    a_volume_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_VOLUME) |-> (o_end_of_entry && !o_end_of_string))
        else $error("volume result without end of entry");

    // the length-error marker carries no character and ends its string
    a_err_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_length_error) |-> (o_end_of_string && o_char_code == 8'd0))
        else $error("length error marker malformed");

endmodule
